>>> rtl/core/gmb_pkg.sv
// Shared types, constants and the direction-order table for the maze backtracker.
// No dependencies; imported by every module of the block.
package gmb_pkg;

    localparam int CFG_W     = 7;
    localparam int FIELD_W   = 6;
    localparam int ORD_W     = 5;
    localparam int EV_W      = 2;
    localparam int REG_IDX_W = 1;
    localparam int ORD_COUNT = 24;

    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_STACK_DEPTH = 1024;

    localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

    localparam logic [REG_IDX_W-1:0] REG_GRID_W = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_H = 1'd1;

    localparam logic [1:0] DIR_XP = 2'd0;
    localparam logic [1:0] DIR_XM = 2'd1;
    localparam logic [1:0] DIR_YP = 2'd2;
    localparam logic [1:0] DIR_YM = 2'd3;

    typedef enum logic [EV_W-1:0] {
        EV_START  = 2'd0,
        EV_CARVE  = 2'd1,
        EV_BACK   = 2'd2,
        EV_FINISH = 2'd3
    } t_ev;

    typedef enum logic [2:0] {
        WS_CLEAR = 3'd0,
        WS_START = 3'd1,
        WS_NB    = 3'd2,
        WS_NEW   = 3'd3,
        WS_WALL  = 3'd4
    } t_wsel;

    typedef struct packed {
        logic       clr_step;
        logic       latch;
        logic       wall_we;
        t_wsel      wall_sel;
        logic       stk_we;
        logic       stk_first;
        logic       stk_rd;
        logic       cnt_set1;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       nb_rd;
        logic [1:0] scan_idx;
        logic       emit;
        t_ev        ev;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic cnt_zero;
        logic cnt_full;
        logic hit;
    } t_sts;

    // four 2-bit directions, first tried in [7:6]; lexicographic over +x,-x,+y,-y
    localparam logic [7:0] PERM_TAB [ORD_COUNT] = '{
        8'b00_01_10_11, 8'b00_01_11_10, 8'b00_10_01_11, 8'b00_10_11_01,
        8'b00_11_01_10, 8'b00_11_10_01, 8'b01_00_10_11, 8'b01_00_11_10,
        8'b01_10_00_11, 8'b01_10_11_00, 8'b01_11_00_10, 8'b01_11_10_00,
        8'b10_00_01_11, 8'b10_00_11_01, 8'b10_01_00_11, 8'b10_01_11_00,
        8'b10_11_00_01, 8'b10_11_01_00, 8'b11_00_01_10, 8'b11_00_10_01,
        8'b11_01_00_10, 8'b11_01_10_00, 8'b11_10_00_01, 8'b11_10_01_00
    };

    function automatic logic [7:0] perm_of(input logic [ORD_W-1:0] code);
        logic [ORD_W-1:0] c;
        c = (code >= ORD_W'(ORD_COUNT)) ? code - ORD_W'(ORD_COUNT) : code;
        return PERM_TAB[c];
    endfunction

endpackage

>>> rtl/core/gmb_dpath.sv
// Datapath: size registers, wall bitmap memory, cell stack memory, neighbour
// checks and result registers. Depends on gmb_pkg; driven by gmb_ctrl.
module gmb_dpath
    import gmb_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [FIELD_W-1:0]   i_start_col,
    input  logic [FIELD_W-1:0]   i_start_row,
    input  logic [ORD_W-1:0]     i_order_code,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_done,
    output logic [EV_W-1:0]      o_event_res,
    output logic [FIELD_W-1:0]   o_cell_col,
    output logic [FIELD_W-1:0]   o_cell_row,
    output logic [FIELD_W-1:0]   o_wall_col,
    output logic [FIELD_W-1:0]   o_wall_row
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int XW    = CW + 1;
    localparam int YW    = RW + 1;
    localparam int WW    = $clog2(MAX_COLS + 1);
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int CWC   = (WW > CFG_W) ? WW : CFG_W;
    localparam int CHC   = (HW > CFG_W) ? HW : CFG_W;
    localparam int SCW   = (WW > FIELD_W) ? WW : FIELD_W;
    localparam int SCH   = (HW > FIELD_W) ? HW : FIELD_W;
    localparam int AW    = CW + RW;
    localparam int MDEP  = 1 << AW;
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int CNTW  = $clog2(STACK_DEPTH + 1);

    logic [CFG_W-1:0]   r_gw, r_gh;
    logic [WW-1:0]      eff_w, wm1;
    logic [HW-1:0]      eff_h, hm1;

    logic [FIELD_W-1:0] r_start_col, r_start_row;
    logic [7:0]         r_perm;
    logic [CW-1:0]      sc;
    logic [RW-1:0]      sr;

    logic               r_wall [MDEP];
    logic               r_open;
    logic [AW-1:0]      waddr;
    logic               wdata;
    logic [AW-1:0]      r_clr_cnt;

    logic [AW-1:0]      r_stk [STACK_DEPTH];
    logic [AW-1:0]      r_top;
    logic [SAW-1:0]     saddr;
    logic [AW-1:0]      sdata;
    logic [CNTW-1:0]    r_cnt, cnt_m1;

    logic [CW-1:0]      x;
    logic [RW-1:0]      y;
    logic [1:0]         d;
    logic [XW-1:0]      nx, wx;
    logic [YW-1:0]      ny, wy;
    logic               neg, ok;
    logic               r_nb_ok;
    logic [CW-1:0]      r_nb_col, r_wl_col;
    logic [RW-1:0]      r_nb_row, r_wl_row;

    logic               r_done;
    logic [EV_W-1:0]    r_ev;
    logic [FIELD_W-1:0] r_cc, r_cr, r_wc, r_wr;

    // size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= GRID_RESET;
            r_gh <= GRID_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_GRID_W) r_gw <= i_cfg_data;
            if (i_cfg_idx == REG_GRID_H) r_gh <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_gw == '0) eff_w = WW'(1);
        else if (CWC'(r_gw) > CWC'(MAX_COLS)) eff_w = WW'(MAX_COLS);
        else eff_w = WW'(r_gw);
        if (r_gh == '0) eff_h = HW'(1);
        else if (CHC'(r_gh) > CHC'(MAX_ROWS)) eff_h = HW'(MAX_ROWS);
        else eff_h = HW'(r_gh);
        wm1 = eff_w - WW'(1);
        hm1 = eff_h - HW'(1);
        sc  = (SCW'(r_start_col) > SCW'(wm1)) ? CW'(wm1) : CW'(r_start_col);
        sr  = (SCH'(r_start_row) > SCH'(hm1)) ? RW'(hm1) : RW'(r_start_row);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_start_col <= i_start_col;
            r_start_row <= i_start_row;
            r_perm      <= perm_of(i_order_code);
        end
    end

    // neighbour of the direction under test
    assign x = r_top[CW-1:0];
    assign y = r_top[AW-1:CW];

    always_comb begin
        case (i_cmd.scan_idx)
            2'd0:    d = r_perm[7:6];
            2'd1:    d = r_perm[5:4];
            2'd2:    d = r_perm[3:2];
            default: d = r_perm[1:0];
        endcase
        nx  = XW'(x);
        wx  = XW'(x);
        ny  = YW'(y);
        wy  = YW'(y);
        neg = 1'b0;
        case (d)
            DIR_XP: begin
                nx = XW'(x) + XW'(2);
                wx = XW'(x) + XW'(1);
            end
            DIR_XM: begin
                nx  = XW'(x) - XW'(2);
                wx  = XW'(x) - XW'(1);
                neg = (XW'(x) < XW'(2));
            end
            DIR_YP: begin
                ny = YW'(y) + YW'(2);
                wy = YW'(y) + YW'(1);
            end
            default: begin
                ny  = YW'(y) - YW'(2);
                wy  = YW'(y) - YW'(1);
                neg = (YW'(y) < YW'(2));
            end
        endcase
        ok = !neg && (nx < XW'(eff_w)) && (ny < YW'(eff_h));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.nb_rd) begin
            r_nb_ok  <= ok;
            r_nb_col <= nx[CW-1:0];
            r_nb_row <= ny[RW-1:0];
            r_wl_col <= wx[CW-1:0];
            r_wl_row <= wy[RW-1:0];
        end
    end

    // wall bitmap, stored as open bits; cleared by a sweep after reset
    always_comb begin
        case (i_cmd.wall_sel)
            WS_CLEAR: waddr = r_clr_cnt;
            WS_START: waddr = {sr, sc};
            WS_NB:    waddr = {ny[RW-1:0], nx[CW-1:0]};
            WS_NEW:   waddr = {r_nb_row, r_nb_col};
            WS_WALL:  waddr = {r_wl_row, r_wl_col};
            default:  waddr = r_clr_cnt;
        endcase
        wdata = (i_cmd.wall_sel != WS_CLEAR);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wall_we) r_wall[waddr] <= wdata;
        r_open <= r_wall[waddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_cnt <= '0;
        else if (i_cmd.clr_step) r_clr_cnt <= r_clr_cnt + AW'(1);
    end

    // cell stack
    assign cnt_m1 = r_cnt - CNTW'(1);

    always_comb begin
        if (i_cmd.stk_first) begin
            saddr = '0;
            sdata = {sr, sc};
        end else if (i_cmd.stk_we) begin
            saddr = r_cnt[SAW-1:0];
            sdata = {r_nb_row, r_nb_col};
        end else begin
            saddr = cnt_m1[SAW-1:0];
            sdata = {r_nb_row, r_nb_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stk_we) r_stk[saddr] <= sdata;
        if (i_cmd.stk_rd) r_top <= r_stk[saddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else if (i_cmd.cnt_set1) r_cnt <= CNTW'(1);
        else if (i_cmd.cnt_inc) r_cnt <= r_cnt + CNTW'(1);
        else if (i_cmd.cnt_dec) r_cnt <= cnt_m1;
    end

    assign o_sts.clr_last = &r_clr_cnt;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_full = (r_cnt >= CNTW'(STACK_DEPTH));
    assign o_sts.hit      = r_nb_ok && !r_open;

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= i_cmd.emit;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ev <= i_cmd.ev;
            r_wc <= '0;
            r_wr <= '0;
            case (i_cmd.ev)
                EV_START: begin
                    r_cc <= FIELD_W'(sc);
                    r_cr <= FIELD_W'(sr);
                end
                EV_CARVE: begin
                    r_cc <= FIELD_W'(r_nb_col);
                    r_cr <= FIELD_W'(r_nb_row);
                    r_wc <= FIELD_W'(r_wl_col);
                    r_wr <= FIELD_W'(r_wl_row);
                end
                EV_BACK: begin
                    r_cc <= FIELD_W'(x);
                    r_cr <= FIELD_W'(y);
                end
                default: begin
                    r_cc <= '0;
                    r_cr <= '0;
                end
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_event_res = r_ev;
    assign o_cell_col  = r_cc;
    assign o_cell_row  = r_cr;
    assign o_wall_col  = r_wc;
    assign o_wall_row  = r_wr;

endmodule

>>> rtl/core/gmb_ctrl.sv
// Controller: clearing sweep, run phase and per-step sequencing of the datapath.
// Depends on gmb_pkg; commands gmb_dpath through t_cmd and reads t_sts.
module gmb_ctrl
    import gmb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_START = 9'b000000100,
        ST_STK   = 9'b000001000,
        ST_SCAN  = 9'b000010000,
        ST_PUSH  = 9'b000100000,
        ST_WALL  = 9'b001000000,
        ST_POP   = 9'b010000000,
        ST_FIN   = 9'b100000000
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_GEN  = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    localparam logic [2:0] SCAN_LAST = 3'd4;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [2:0] r_k, n_k;
    logic       accept;

    assign accept = i_start && (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.wall_sel = WS_CLEAR;
        o_cmd.ev       = EV_START;
        o_cmd.scan_idx = r_k[1:0];
        case (r_state)
            ST_CLEAR: begin
                o_cmd.wall_we  = 1'b1;
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    if (r_phase == PH_IDLE) begin
                        n_state = ST_START;
                        n_phase = PH_GEN;
                    end else if (r_phase == PH_GEN && !i_sts.cnt_zero) begin
                        n_state = ST_STK;
                    end else begin
                        n_state = ST_FIN;
                        n_phase = PH_DONE;
                    end
                end
            end
            ST_START: begin
                o_cmd.wall_we   = 1'b1;
                o_cmd.wall_sel  = WS_START;
                o_cmd.stk_we    = 1'b1;
                o_cmd.stk_first = 1'b1;
                o_cmd.cnt_set1  = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.ev        = EV_START;
                n_state         = ST_IDLE;
            end
            ST_STK: begin
                o_cmd.stk_rd = 1'b1;
                n_k          = '0;
                n_state      = i_sts.cnt_full ? ST_POP : ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.wall_sel = WS_NB;
                if (r_k != '0 && i_sts.hit) begin
                    n_state = ST_PUSH;
                end else if (r_k == SCAN_LAST) begin
                    n_state = ST_POP;
                end else begin
                    o_cmd.nb_rd = 1'b1;
                    n_k         = r_k + 3'd1;
                end
            end
            ST_PUSH: begin
                o_cmd.wall_we  = 1'b1;
                o_cmd.wall_sel = WS_NEW;
                o_cmd.stk_we   = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                n_state        = ST_WALL;
            end
            ST_WALL: begin
                o_cmd.wall_we  = 1'b1;
                o_cmd.wall_sel = WS_WALL;
                o_cmd.emit     = 1'b1;
                o_cmd.ev       = EV_CARVE;
                n_state        = ST_IDLE;
            end
            ST_POP: begin
                o_cmd.cnt_dec = 1'b1;
                o_cmd.emit    = 1'b1;
                o_cmd.ev      = EV_BACK;
                n_state       = ST_IDLE;
            end
            ST_FIN: begin
                o_cmd.emit = 1'b1;
                o_cmd.ev   = EV_FINISH;
                n_state    = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_phase <= PH_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_k     <= n_k;
        end
    end

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) |-> !i_sts.cnt_full)
        else $error("push on full stack");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |-> !i_sts.cnt_zero)
        else $error("pop on empty stack");

    a_idle_phase_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> i_sts.cnt_zero)
        else $error("stack in use before first step");

    a_done_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_DONE) |=> (r_state == ST_FIN))
        else $error("step after end of run did not finish");

endmodule

>>> rtl/core/grid_maze_backtracker_step.sv
// Top level of the recursive-backtracker maze step engine.
// Depends on gmb_pkg, gmb_ctrl and gmb_dpath.
//
// Use: pulse i_start with the start cell and order code while o_busy is low;
// the word is taken at that edge. Exactly one result word follows, shown for
// one cycle with o_done high; the receiver cannot hold it off.
// A start or finish step goes straight to its result; a step on a full stack
// reads the stack top and backtracks, and any other step reads the stack top
// and scans. Up to four neighbour reads go one per cycle through the single
// port of the wall bitmap, followed by two wall writes on a carve; o_busy
// drops in the cycle that o_done shows, so the next step may start then.
// Grid size registers are written through i_cfg_we / i_cfg_idx / i_cfg_data
// and take effect on the next step; write them only while o_busy is low.
// The wall bitmap holds 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) cells (4096 at
// default size); after reset it is swept to all walls, one cell a cycle, and
// o_busy is high until the sweep ends. Size registers reset to 64 by 64.
module grid_maze_backtracker_step
    import gmb_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [FIELD_W-1:0]   i_start_col,
    input  logic [FIELD_W-1:0]   i_start_row,
    input  logic [ORD_W-1:0]     i_order_code,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_done,
    output logic [EV_W-1:0]      o_event_res,
    output logic [FIELD_W-1:0]   o_cell_col,
    output logic [FIELD_W-1:0]   o_cell_row,
    output logic [FIELD_W-1:0]   o_wall_col,
    output logic [FIELD_W-1:0]   o_wall_row
);

    t_cmd cmd;
    t_sts sts;

    gmb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    gmb_dpath #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_start_col  (i_start_col),
        .i_start_row  (i_start_row),
        .i_order_code (i_order_code),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_done       (o_done),
        .o_event_res  (o_event_res),
        .o_cell_col   (o_cell_col),
        .o_cell_row   (o_cell_row),
        .o_wall_col   (o_wall_col),
        .o_wall_row   (o_wall_row)
    );

endmodule

>>> test/grid_maze_backtracker_step_check.sv
// Carve checker for grid_maze_backtracker_step: keeps its own grid, cell stack and sizes,
// predicts one result word per accepted step and compares it with the strobed result.
// Depends on gmb_pkg.
`timescale 1ns / 100ps

module grid_maze_backtracker_step_check
    import gmb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [FIELD_W-1:0]   i_start_col,
    input  logic [FIELD_W-1:0]   i_start_row,
    input  logic [ORD_W-1:0]     i_order_code,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_done,
    input  logic [EV_W-1:0]      i_event_res,
    input  logic [FIELD_W-1:0]   i_cell_col,
    input  logic [FIELD_W-1:0]   i_cell_row,
    input  logic [FIELD_W-1:0]   i_wall_col,
    input  logic [FIELD_W-1:0]   i_wall_row,
    output int                   o_fail_count,
    output int                   o_waiting
);

    localparam int COLS  = DEF_MAX_COLS;
    localparam int ROWS  = DEF_MAX_ROWS;
    localparam int DEPTH = DEF_STACK_DEPTH;

    typedef enum logic [1:0] {
        RUN_IDLE,
        RUN_CARVING,
        RUN_OVER
    } t_run;

    typedef struct packed {
        t_ev                ev;
        logic [FIELD_W-1:0] cell_col;
        logic [FIELD_W-1:0] cell_row;
        logic [FIELD_W-1:0] wall_col;
        logic [FIELD_W-1:0] wall_row;
    } t_step_word;

    bit                 is_wall [ROWS][COLS];
    logic [FIELD_W-1:0] path_col [DEPTH];
    logic [FIELD_W-1:0] path_row [DEPTH];
    int                 path_len;
    t_run               run_state;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    t_step_word         due_words [$];

    initial begin
        o_fail_count = 0;
        o_waiting    = 0;
    end

    function automatic int clip_size(input logic [CFG_W-1:0] v, input int lim);
        if (v == '0)
            return 1;
        if (int'(v) > lim)
            return lim;
        return int'(v);
    endfunction

    // first direction in [7:6]; lexicographic over +x,-x,+y,-y
    function automatic logic [7:0] dir_order(input logic [ORD_W-1:0] code);
        int         c;
        int         f;
        int         pick;
        int         left;
        logic [1:0] pool [4];
        logic [7:0] seq;
        c       = int'(code) % ORD_COUNT;
        pool[0] = DIR_XP;
        pool[1] = DIR_XM;
        pool[2] = DIR_YP;
        pool[3] = DIR_YM;
        left    = 4;
        seq     = '0;
        for (int i = 0; i < 4; i++) begin
            f    = (i == 0) ? 6 : (i == 1) ? 2 : 1;
            pick = c / f;
            c    = c % f;
            seq  = {seq[5:0], pool[pick]};
            for (int j = pick; j < left - 1; j++)
                pool[j] = pool[j + 1];
            left--;
        end
        return seq;
    endfunction

    function automatic t_step_word carve_step(input logic [FIELD_W-1:0] s_col,
                                              input logic [FIELD_W-1:0] s_row,
                                              input logic [ORD_W-1:0]   code);
        int         w;
        int         h;
        int         x;
        int         y;
        int         dx;
        int         dy;
        int         nx;
        int         ny;
        logic [7:0] seq;
        logic [1:0] d;
        bit         moved;
        t_step_word r;
        w     = clip_size(width_reg, COLS);
        h     = clip_size(height_reg, ROWS);
        r     = '0;
        moved = 1'b0;
        if (run_state == RUN_IDLE) begin
            x = (int'(s_col) > w - 1) ? w - 1 : int'(s_col);
            y = (int'(s_row) > h - 1) ? h - 1 : int'(s_row);
            is_wall[y][x] = 1'b0;
            path_col[0]   = FIELD_W'(x);
            path_row[0]   = FIELD_W'(y);
            path_len      = 1;
            run_state     = RUN_CARVING;
            r.ev          = EV_START;
            r.cell_col    = FIELD_W'(x);
            r.cell_row    = FIELD_W'(y);
        end else if (run_state == RUN_CARVING && path_len > 0) begin
            x   = int'(path_col[path_len - 1]);
            y   = int'(path_row[path_len - 1]);
            seq = dir_order(code);
            if (path_len < DEPTH) begin
                for (int k = 0; k < 4; k++) begin
                    if (!moved) begin
                        d = seq[7 - 2 * k -: 2];
                        case (d)
                            DIR_XP: begin dx = 1;  dy = 0;  end
                            DIR_XM: begin dx = -1; dy = 0;  end
                            DIR_YP: begin dx = 0;  dy = 1;  end
                            default: begin dx = 0; dy = -1; end
                        endcase
                        nx = x + 2 * dx;
                        ny = y + 2 * dy;
                        if (nx >= 0 && nx < w && ny >= 0 && ny < h && is_wall[ny][nx]) begin
                            is_wall[ny][nx]         = 1'b0;
                            is_wall[y + dy][x + dx] = 1'b0;
                            path_col[path_len]      = FIELD_W'(nx);
                            path_row[path_len]      = FIELD_W'(ny);
                            path_len++;
                            r.ev       = EV_CARVE;
                            r.cell_col = FIELD_W'(nx);
                            r.cell_row = FIELD_W'(ny);
                            r.wall_col = FIELD_W'(x + dx);
                            r.wall_row = FIELD_W'(y + dy);
                            moved      = 1'b1;
                        end
                    end
                end
            end
            if (!moved) begin
                path_len--;
                r.ev       = EV_BACK;
                r.cell_col = FIELD_W'(x);
                r.cell_row = FIELD_W'(y);
            end
        end else begin
            run_state = RUN_OVER;
            r.ev      = EV_FINISH;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                        input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_step_word want;
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLS; c++)
                    is_wall[r][c] = 1'b1;
            path_len   = 0;
            run_state  = RUN_IDLE;
            width_reg  = GRID_RESET;
            height_reg = GRID_RESET;
            due_words.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_GRID_W)
                    width_reg = i_cfg_data;
                else if (i_cfg_idx == REG_GRID_H)
                    height_reg = i_cfg_data;
            end
            if (i_done) begin
                if (due_words.size() == 0) begin
                    $error("result word with no step waiting: event_res %0d", i_event_res);
                    o_fail_count++;
                end else begin
                    want = due_words.pop_front();
                    check_field("event_res", FIELD_W'(want.ev), FIELD_W'(i_event_res));
                    check_field("cell_col", want.cell_col, i_cell_col);
                    check_field("cell_row", want.cell_row, i_cell_row);
                    check_field("wall_col", want.wall_col, i_wall_col);
                    check_field("wall_row", want.wall_row, i_wall_row);
                end
            end
            if (i_start && !i_busy)
                due_words.push_back(carve_step(i_start_col, i_start_row, i_order_code));
        end
        o_waiting = due_words.size();
    end

endmodule

>>> test/grid_maze_backtracker_step_test.sv
// Testbench top for grid_maze_backtracker_step: drives steps and size writes, then gives
// the verdict. Depends on gmb_pkg, the block and grid_maze_backtracker_step_check.
`timescale 1ns / 100ps

module grid_maze_backtracker_step_test;
    import gmb_pkg::*;

    localparam int RANDOM_STEPS = 600;
    localparam int CYCLE_LIMIT  = 400_000;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_start      = 1'b0;
    logic [FIELD_W-1:0]   i_start_col  = '0;
    logic [FIELD_W-1:0]   i_start_row  = '0;
    logic [ORD_W-1:0]     i_order_code = '0;
    logic                 i_cfg_we     = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_idx    = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 o_busy;
    logic                 o_done;
    logic [EV_W-1:0]      o_event_res;
    logic [FIELD_W-1:0]   o_cell_col;
    logic [FIELD_W-1:0]   o_cell_row;
    logic [FIELD_W-1:0]   o_wall_col;
    logic [FIELD_W-1:0]   o_wall_row;

    int          fail_count;
    int          words_waiting;
    int unsigned cycle_count = 0;
    int          n_sent      = 0;
    int          n_done      = 0;
    int          n_cfg       = 0;
    int          n_started   = 0;
    int          n_carved    = 0;
    int          n_back      = 0;
    int          n_finished  = 0;
    int          stack_depth = 0;
    int          deepest     = 0;
    bit          run_over    = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    grid_maze_backtracker_step dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_start_col  (i_start_col),
        .i_start_row  (i_start_row),
        .i_order_code (i_order_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_event_res  (o_event_res),
        .o_cell_col   (o_cell_col),
        .o_cell_row   (o_cell_row),
        .o_wall_col   (o_wall_col),
        .o_wall_row   (o_wall_row)
    );

    grid_maze_backtracker_step_check u_carve_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_start_col  (i_start_col),
        .i_start_row  (i_start_row),
        .i_order_code (i_order_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_done       (o_done),
        .i_event_res  (o_event_res),
        .i_cell_col   (o_cell_col),
        .i_cell_row   (o_cell_row),
        .i_wall_col   (o_wall_col),
        .i_wall_row   (o_wall_row),
        .o_fail_count (fail_count),
        .o_waiting    (words_waiting)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (stack_depth > deepest)
            deepest <= stack_depth;
        if (i_rst_n) begin
            if (i_start && !o_busy)
                n_sent <= n_sent + 1;
            if (i_cfg_we)
                n_cfg <= n_cfg + 1;
            if (o_done) begin
                n_done <= n_done + 1;
                case (o_event_res)
                    EV_START: begin
                        n_started   <= n_started + 1;
                        stack_depth <= stack_depth + 1;
                    end
                    EV_CARVE: begin
                        n_carved    <= n_carved + 1;
                        stack_depth <= stack_depth + 1;
                    end
                    EV_BACK: begin
                        n_back      <= n_back + 1;
                        stack_depth <= stack_depth - 1;
                    end
                    default: begin
                        n_finished <= n_finished + 1;
                        run_over   <= 1'b1;
                    end
                endcase
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    // returns at the edge that takes the word; start stays high
    task automatic send_step(input logic [FIELD_W-1:0] col, input logic [FIELD_W-1:0] row,
                             input logic [ORD_W-1:0] code);
        i_start      <= 1'b1;
        i_start_col  <= col;
        i_start_row  <= row;
        i_order_code <= code;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic quiesce();
        i_start <= 1'b0;
        do @(posedge i_clk); while (n_done != n_sent || o_busy);
    endtask

    task automatic write_size(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return CFG_W'($urandom_range(64, 127));
        if (r < 8)
            return CFG_W'($urandom_range(4, 63));
        return CFG_W'($urandom_range(0, 3));
    endfunction

    initial begin : stimulus
        int               lead_codes [12];
        int               sent;
        int               seg_len;
        int               k;
        bit               burst;
        bit               narrow;
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;
        lead_codes = '{0, 31, 6, 18, 24, 12, 9, 23, 3, 27, 15, 21};
        sent       = 0;
        narrow     = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);

        // zero sizes count as one: start far outside is clamped to the corner
        write_size(REG_GRID_W, '0);
        write_size(REG_GRID_H, '0);
        send_step(FIELD_W'(63), FIELD_W'(63), ORD_W'(23));
        quiesce();
        write_size(REG_GRID_W, CFG_W'(127));
        write_size(REG_GRID_H, CFG_W'(64));
        foreach (lead_codes[i])
            send_step((i % 2) ? FIELD_W'(63) : FIELD_W'(0), (i % 3) ? FIELD_W'(0) : FIELD_W'(63),
                      ORD_W'(lead_codes[i]));
        // shrink under a running carve: top cells now out of range
        quiesce();
        write_size(REG_GRID_W, CFG_W'(1));
        write_size(REG_GRID_H, CFG_W'(1));
        repeat (2) send_step(FIELD_W'(0), FIELD_W'(0), ORD_W'(0));
        quiesce();
        write_size(REG_GRID_W, CFG_W'(65));
        write_size(REG_GRID_H, CFG_W'(126));

        while (sent < RANDOM_STEPS) begin
            seg_len = $urandom_range(15, 70);
            burst   = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0) begin
                quiesce();
                wv = pick_size();
                hv = pick_size();
                write_size(REG_GRID_W, wv);
                write_size(REG_GRID_H, hv);
                narrow = (wv < 64) || (hv < 64);
            end
            k = 0;
            // keep the stack from draining while the grid is cut down
            while (k < seg_len && !(narrow && stack_depth <= 6)) begin
                send_step(FIELD_W'($urandom_range(0, 63)), FIELD_W'($urandom_range(0, 63)),
                          ORD_W'($urandom_range(0, 31)));
                k++;
                sent++;
                if (!burst)
                    idle_gap(gap_len());
            end
            if (narrow) begin
                quiesce();
                write_size(REG_GRID_W, CFG_W'($urandom_range(64, 127)));
                write_size(REG_GRID_H, CFG_W'(64));
                narrow = 1'b0;
            end
        end

        // one-cell grid: everything pops, then the run ends
        quiesce();
        write_size(REG_GRID_W, CFG_W'(0));
        write_size(REG_GRID_H, CFG_W'(1));
        while (!run_over)
            send_step(FIELD_W'($urandom_range(0, 63)), FIELD_W'($urandom_range(0, 63)),
                      ORD_W'($urandom_range(0, 31)));
        repeat (3) begin
            idle_gap(gap_len());
            send_step(FIELD_W'($urandom_range(0, 63)), FIELD_W'($urandom_range(0, 63)),
                      ORD_W'($urandom_range(0, 31)));
        end
        quiesce();
        repeat (12) @(posedge i_clk);

        $display("%0d step words: %0d started, %0d carved, %0d backtracked, %0d finished",
                 n_done, n_started, n_carved, n_back, n_finished);
        $display("%0d grid size writes, deepest cell stack %0d", n_cfg, deepest);
        if (fail_count == 0 && words_waiting == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
